// File: sv/bitmap_block_allocator_unit_macros.svh
// Assertion macros for the bitmap block allocator unit.
`ifndef BITMAP_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off during reset.
`define BBA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bitmap allocator check failed");
// Next-cycle implication, sampled on clk, off during reset.
`define BBA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bitmap allocator check failed");
`else
`define BBA_ASSERT_IMP(lbl, ante, cons)
`define BBA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: sv/bba_pkg.sv
// Shared types and constants of the bitmap block allocator.
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;

    localparam int CMD_W   = 2;
    localparam int ADDR_W  = 32;
    localparam int SIZE_W  = 17;
    localparam int COUNT_W = 13;
    localparam int BIDX_W  = 9;
    localparam int BYTE_W  = 8;
    localparam int STAT_W  = 2;
    localparam int CFG_IDX_W = 2;

    // Map word geometry: eight bytes, 64 objects per memory word.
    localparam int WORD_BYTES = 8;
    localparam int WORD_W     = WORD_BYTES * BYTE_W;
    localparam int BIT_W      = $clog2(BYTE_W);
    localparam int LANE_W     = $clog2(WORD_BYTES);
    localparam int POS_W      = $clog2(WORD_W);

    typedef enum logic [CMD_W-1:0] {
        CMD_FIND      = 2'd0,
        CMD_MARK_USED = 2'd1,
        CMD_MARK_FREE = 2'd2,
        CMD_LOAD      = 2'd3
    } cmd_e;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

    localparam logic [ADDR_W-1:0]  BASE_RESET  = 32'd0;
    localparam logic [SIZE_W-1:0]  SIZE_RESET  = 17'd1024;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage
`default_nettype wire

// File: sv/bba_cmd_if.sv
// Command channel of the bitmap block allocator.
`timescale 1ns / 1ps
`default_nettype none
interface bba_cmd_if import bba_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] address;
    logic [BIDX_W-1:0] byte_index;
    logic [BYTE_W-1:0] byte_data;

    modport source (output valid, command, address, byte_index, byte_data, input ready);
    modport sink   (input valid, command, address, byte_index, byte_data, output ready);
endinterface
`default_nettype wire

// File: sv/bba_res_if.sv
// Result channel of the bitmap block allocator.
`timescale 1ns / 1ps
`default_nettype none
interface bba_res_if import bba_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] free_address;
    logic [STAT_W-1:0] status;
    logic              store_write;
    logic [BIDX_W-1:0] store_index;
    logic [BYTE_W-1:0] store_byte;

    modport source (output valid, free_address, status, store_write, store_index,
                    store_byte, input ready);
    modport sink   (input valid, free_address, status, store_write, store_index,
                    store_byte, output ready);
endinterface
`default_nettype wire

// File: sv/bitmap_block_allocator_unit.sv
// Top level of the bitmap block allocator: sequencer, configuration and result register.
//
// Usage
//   cmd carries one command per transaction (find, mark used, mark free, load byte);
//   res returns exactly one result transaction for each command, in order.
//   cfg_we/cfg_index/cfg_data write object_base (0), object_size (1) and
//   object_count (2); write only while no command is in flight.
//   Steps per command, from accept to result register:
//     find       : scan the map words in order (64 objects per word), then multiply
//                  and add; both are skipped when no free object is found.
//                  the map memory read port delivers one word per cycle.
//     mark       : range check, 32-step restoring divider, read-modify-write.
//     load       : read, modify, write of one map word.
//   Commands run one at a time; the next command is taken as soon as the
//   previous result sits in the output register.
//   Reset clears the map by sweeping every memory word; cmd.ready stays low meanwhile.
//   When res stalls, the finished result holds in the output register, one
//   more command may be processed, and its result waits until res drains.
`timescale 1ns / 1ps
`default_nettype none
`include "bitmap_block_allocator_unit_macros.svh"
module bitmap_block_allocator_unit import bba_pkg::*; #(
    parameter int MAX_OBJECTS = 4096
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    bba_cmd_if.sink                   cmd,
    bba_res_if.source                 res,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ADDR_W-1:0]    cfg_data
);
    // Map geometry derived from the object capacity.
    localparam int MAP_BYTES = (MAX_OBJECTS + 7) / 8;
    localparam int MAP_WORDS = (MAP_BYTES + WORD_BYTES - 1) / WORD_BYTES;
    localparam int WA        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int CNT_W     = $clog2(MAX_OBJECTS + 1);
    localparam int IDX_W     = WA + POS_W;
    localparam int PW        = IDX_W + SIZE_W;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIND_SCAN,
        ST_MUL,
        ST_ADD,
        ST_CHK,
        ST_DIV,
        ST_RMW_RD,
        ST_RMW_WR,
        ST_RESULT
    } state_t;

    state_t            state_reg;

    logic [ADDR_W-1:0]  cfg_base_reg;
    logic [SIZE_W-1:0]  cfg_size_reg;
    logic [COUNT_W-1:0] cfg_count_reg;

    cmd_e              op_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [BYTE_W-1:0] bdata_reg;

    logic [WA-1:0]     clr_addr_reg;
    logic [WA-1:0]     scan_w_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [IDX_W-1:0]  found_reg;
    logic [PW-1:0]     prod_reg;
    logic [WA-1:0]     rmw_addr_reg;
    logic [LANE_W-1:0] rmw_lane_reg;
    logic [BIT_W-1:0]  rmw_bit_reg;

    logic [ADDR_W-1:0] pend_free_reg;
    logic [STAT_W-1:0] pend_status_reg;
    logic              pend_sw_reg;
    logic [BIDX_W-1:0] pend_idx_reg;
    logic [BYTE_W-1:0] pend_byte_reg;

    logic              out_valid_reg;
    logic [ADDR_W-1:0] out_free_reg;
    logic [STAT_W-1:0] out_status_reg;
    logic              out_sw_reg;
    logic [BIDX_W-1:0] out_idx_reg;
    logic [BYTE_W-1:0] out_byte_reg;

    logic [CNT_W-1:0]  live_count;
    logic [WORD_W-1:0] scan_mask;
    logic [WORD_W-1:0] free_bits;
    logic [POS_W-1:0]  scan_pos;
    logic              mark_ok;
    logic [BYTE_W-1:0] old_byte;
    logic [BYTE_W-1:0] bit_mask;
    logic [BYTE_W-1:0] new_byte;
    logic [WORD_W-1:0] new_word;

    logic              ram_we;
    logic [WA-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WA-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    logic              div_start;
    logic [ADDR_W-1:0] div_quo;
    div_stat_t         div_stat;

    // Lowest set bit of a map word.
    function automatic logic [POS_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
        logic [POS_W-1:0] r;
        r = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = POS_W'(i);
            end
        end
        return r;
    endfunction

    // Clamp the configured count to the map capacity.
    assign live_count = (int'(cfg_count_reg) > MAX_OBJECTS) ? CNT_W'(MAX_OBJECTS)
                                                            : CNT_W'(cfg_count_reg);

    // Scan: only bits below the remaining count are candidates.
    always_comb
    begin
        if (int'(rem_reg) >= WORD_W)
        begin
            scan_mask = '1;
        end
        else
        begin
            scan_mask = (WORD_W'(1) << rem_reg) - WORD_W'(1);
        end
        free_bits = ~ram_rdata & scan_mask;
        scan_pos  = lowest_set(free_bits);
    end

    assign mark_ok = (addr_reg >= cfg_base_reg) && (cfg_size_reg != '0);

    // Read-modify-write of one byte lane of the fetched map word.
    always_comb
    begin
        old_byte = ram_rdata[BYTE_W * rmw_lane_reg +: BYTE_W];
        bit_mask = BYTE_W'(1) << rmw_bit_reg;
        case (op_reg)
            CMD_MARK_USED: new_byte = old_byte | bit_mask;
            CMD_MARK_FREE: new_byte = old_byte & ~bit_mask;
            default:       new_byte = bdata_reg;
        endcase
        new_word = ram_rdata;
        new_word[BYTE_W * rmw_lane_reg +: BYTE_W] = new_byte;
    end

    // Memory port steering: the clear sweep and the write-back share the write port.
    always_comb
    begin
        ram_we    = (state_reg == ST_CLEAR) || (state_reg == ST_RMW_WR);
        ram_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : rmw_addr_reg;
        ram_wdata = (state_reg == ST_CLEAR) ? '0 : new_word;
        case (state_reg)
            ST_FIND_SCAN: ram_raddr = WA'(scan_w_reg + 1'b1);
            ST_RMW_RD:    ram_raddr = rmw_addr_reg;
            default:      ram_raddr = '0;
        endcase
    end

    assign div_start = (state_reg == ST_CHK) && mark_ok;

    bba_map_ram #(
        .AW(WA)
    ) u_map (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    bba_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(addr_reg - cfg_base_reg),
        .divisor (cfg_size_reg),
        .quotient(div_quo),
        .stat    (div_stat)
    );

    // Configuration registers; indexes beyond the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_base_reg  <= BASE_RESET;
            cfg_size_reg  <= SIZE_RESET;
            cfg_count_reg <= COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BASE:  cfg_base_reg  <= cfg_data;
                CFG_SIZE:  cfg_size_reg  <= cfg_data[SIZE_W-1:0];
                CFG_COUNT: cfg_count_reg <= cfg_data[COUNT_W-1:0];
                default:   ;
            endcase
        end
    end

    // Sequencer and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            op_reg          <= CMD_FIND;
            addr_reg        <= '0;
            bdata_reg       <= '0;
            clr_addr_reg    <= '0;
            scan_w_reg      <= '0;
            rem_reg         <= '0;
            found_reg       <= '0;
            prod_reg        <= '0;
            rmw_addr_reg    <= '0;
            rmw_lane_reg    <= '0;
            rmw_bit_reg     <= '0;
            pend_free_reg   <= '0;
            pend_status_reg <= STAT_OK;
            pend_sw_reg     <= 1'b0;
            pend_idx_reg    <= '0;
            pend_byte_reg   <= '0;
            out_valid_reg   <= 1'b0;
            out_free_reg    <= '0;
            out_status_reg  <= STAT_OK;
            out_sw_reg      <= 1'b0;
            out_idx_reg     <= '0;
            out_byte_reg    <= '0;
        end
        else
        begin
            // Drop the result once the receiver takes it, unless a new one replaces it.
            if (out_valid_reg && res.ready && (state_reg != ST_RESULT))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == '1)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end

                ST_IDLE:
                begin
                    if (cmd.valid)
                    begin
                        op_reg          <= cmd_e'(cmd.command);
                        addr_reg        <= cmd.address;
                        bdata_reg       <= cmd.byte_data;
                        pend_free_reg   <= '0;
                        pend_status_reg <= STAT_OK;
                        pend_sw_reg     <= 1'b0;
                        pend_idx_reg    <= '0;
                        pend_byte_reg   <= '0;
                        case (cmd_e'(cmd.command))
                            CMD_FIND:
                            begin
                                // Word 0 is being read right now.
                                scan_w_reg <= '0;
                                rem_reg    <= live_count;
                                state_reg  <= ST_FIND_SCAN;
                            end
                            CMD_MARK_USED, CMD_MARK_FREE:
                            begin
                                state_reg <= ST_CHK;
                            end
                            default:
                            begin
                                if (int'(cmd.byte_index) >= MAP_BYTES)
                                begin
                                    pend_status_reg <= STAT_RANGE;
                                    state_reg       <= ST_RESULT;
                                end
                                else
                                begin
                                    rmw_addr_reg <= WA'(cmd.byte_index >> LANE_W);
                                    rmw_lane_reg <= cmd.byte_index[LANE_W-1:0];
                                    pend_idx_reg <= cmd.byte_index;
                                    state_reg    <= ST_RMW_RD;
                                end
                            end
                        endcase
                    end
                end

                ST_FIND_SCAN:
                begin
                    if (rem_reg == '0)
                    begin
                        pend_status_reg <= STAT_FULL;
                        state_reg       <= ST_RESULT;
                    end
                    else if (|free_bits)
                    begin
                        found_reg <= {scan_w_reg, scan_pos};
                        state_reg <= ST_MUL;
                    end
                    else
                    begin
                        // Advance to the word already in flight.
                        scan_w_reg <= WA'(scan_w_reg + 1'b1);
                        if (int'(rem_reg) > WORD_W)
                        begin
                            rem_reg <= CNT_W'(int'(rem_reg) - WORD_W);
                        end
                        else
                        begin
                            rem_reg <= '0;
                        end
                    end
                end

                ST_MUL:
                begin
                    prod_reg  <= PW'(found_reg) * PW'(cfg_size_reg);
                    state_reg <= ST_ADD;
                end

                ST_ADD:
                begin
                    pend_free_reg <= ADDR_W'(prod_reg) + cfg_base_reg;
                    state_reg     <= ST_RESULT;
                end

                ST_CHK:
                begin
                    if (mark_ok)
                    begin
                        state_reg <= ST_DIV;
                    end
                    else
                    begin
                        pend_status_reg <= STAT_RANGE;
                        state_reg       <= ST_RESULT;
                    end
                end

                ST_DIV:
                begin
                    if (div_stat.done)
                    begin
                        if (div_quo >= ADDR_W'(live_count))
                        begin
                            pend_status_reg <= STAT_RANGE;
                            state_reg       <= ST_RESULT;
                        end
                        else
                        begin
                            rmw_addr_reg <= WA'(div_quo >> POS_W);
                            rmw_lane_reg <= div_quo[POS_W-1:BIT_W];
                            rmw_bit_reg  <= div_quo[BIT_W-1:0];
                            pend_idx_reg <= BIDX_W'(div_quo >> BIT_W);
                            state_reg    <= ST_RMW_RD;
                        end
                    end
                end

                ST_RMW_RD:
                begin
                    state_reg <= ST_RMW_WR;
                end

                ST_RMW_WR:
                begin
                    pend_sw_reg   <= 1'b1;
                    pend_byte_reg <= new_byte;
                    state_reg     <= ST_RESULT;
                end

                ST_RESULT:
                begin
                    // Hold until the output register is free.
                    if (!out_valid_reg || res.ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_free_reg   <= pend_free_reg;
                        out_status_reg <= pend_status_reg;
                        out_sw_reg     <= pend_sw_reg;
                        out_idx_reg    <= pend_idx_reg;
                        out_byte_reg   <= pend_byte_reg;
                        state_reg      <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign cmd.ready        = (state_reg == ST_IDLE);
    assign res.valid        = out_valid_reg;
    assign res.free_address = out_free_reg;
    assign res.status       = out_status_reg;
    assign res.store_write  = out_sw_reg;
    assign res.store_index  = out_idx_reg;
    assign res.store_byte   = out_byte_reg;

    // No command may enter while the map is being cleared.
    `BBA_ASSERT_IMP(a_no_cmd_in_clear, state_reg == ST_CLEAR, !cmd.ready)
    // The map memory is written only by the clear sweep or a write-back.
    `BBA_ASSERT_IMP(a_ram_write_phase, ram_we,
        state_reg == ST_CLEAR || state_reg == ST_RMW_WR)
    // The divider runs only while the sequencer waits for it.
    `BBA_ASSERT_IMP(a_div_in_wait, div_stat.busy || div_stat.done, state_reg == ST_DIV)
    // A reported write-back always comes with an ok status.
    `BBA_ASSERT_IMP(a_write_is_ok, res.valid && res.store_write, res.status == STAT_OK)
    // A write-back is always followed by its result being queued.
    `BBA_ASSERT_NXT(a_wb_to_result, state_reg == ST_RMW_WR,
        state_reg == ST_RESULT && pend_sw_reg)
endmodule
`default_nettype wire

// File: sv/bba_map_ram.sv
// Occupancy map memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bba_map_ram import bba_pkg::*; #(
    parameter int AW = 6
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [AW-1:0]     waddr,
    input  wire logic [WORD_W-1:0] wdata,
    input  wire logic [AW-1:0]     raddr,
    output logic      [WORD_W-1:0] rdata
);
    localparam int DEPTH = 1 << AW;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// File: sv/bba_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module bba_div import bba_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [ADDR_W-1:0] dividend,
    input  wire logic [SIZE_W-1:0] divisor,
    output logic      [ADDR_W-1:0] quotient,
    output div_stat_t              stat
);
    localparam int CNT_W = $clog2(ADDR_W);

    logic [ADDR_W-1:0] quo_reg;
    logic [SIZE_W-1:0] rem_reg;
    logic [SIZE_W-1:0] dvs_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [SIZE_W:0]   shifted;
    logic              ge;
    logic [SIZE_W-1:0] diff;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[ADDR_W-1]};
        ge      = shifted >= {1'b0, dvs_reg};
        diff    = SIZE_W'(shifted - {1'b0, dvs_reg});
    end

    // Control: count the quotient bits, pulse done after the last one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift the dividend out and the quotient in.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[ADDR_W-2:0], ge};
            rem_reg <= ge ? diff : shifted[SIZE_W-1:0];
        end
    end

    assign quotient = quo_reg;
    assign stat     = {busy_reg, done_reg};
endmodule
`default_nettype wire

// File: bench/bitmap_block_allocator_unit_test.sv
// Self-checking bench for the bitmap block allocator: directed cases, then random traffic.
`timescale 1ns / 1ps
module bitmap_block_allocator_unit_test;
    import bba_pkg::*;

    // Map geometry for the default MAX_OBJECTS.
    localparam int MAP_OBJECTS = 4096;
    localparam int MAP_BYTES   = MAP_OBJECTS / 8;
    // A find scans at most 64 words.
    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT   = 600_000;
    localparam int LONG_HOLD     = 300;

    typedef struct packed {
        cmd_e              op;
        logic [ADDR_W-1:0] addr;
        logic [BIDX_W-1:0] bidx;
        logic [BYTE_W-1:0] bdata;
    } alloc_cmd_t;

    typedef struct packed {
        logic [ADDR_W-1:0] free_address;
        logic [STAT_W-1:0] status;
        logic              store_write;
        logic [BIDX_W-1:0] store_index;
        logic [BYTE_W-1:0] store_byte;
    } alloc_reply_t;

    logic clk;
    logic rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ADDR_W-1:0]    cfg_data;

    bba_cmd_if cmd_bus ();
    bba_res_if res_bus ();

    bitmap_block_allocator_unit #(
        .MAX_OBJECTS(MAP_OBJECTS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd_bus),
        .res      (res_bus),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Shadow copy of the allocator: occupancy bits and the three registers.
    logic [BYTE_W-1:0]  occupancy [MAP_BYTES];
    logic [ADDR_W-1:0]  base_now;
    logic [SIZE_W-1:0]  size_now;
    logic [COUNT_W-1:0] count_now;

    alloc_cmd_t   command_backlog [$];
    alloc_reply_t predicted_replies [$];
    alloc_cmd_t   next_cmd;

    int  error_count;
    int  cycle_count;
    int  replies_seen;
    int  send_gap;
    int  recv_gap;
    int  long_hold_left;
    bit  long_hold_done;
    bit  gaps_on;

    initial begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Bound the run; a hang anywhere lands here.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic flag_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Apply one command to the shadow map and work out the reply the block owes.
    function automatic alloc_reply_t apply_command(input cmd_e op,
                                                   input logic [ADDR_W-1:0] addr,
                                                   input logic [BIDX_W-1:0] bidx,
                                                   input logic [BYTE_W-1:0] bdata);
        alloc_reply_t      r;
        logic [ADDR_W-1:0] live;
        logic [ADDR_W-1:0] idx;
        logic [ADDR_W-1:0] obj;
        logic [BYTE_W-1:0] mask;
        bit                found;
        r = '0;
        // Counts above capacity act as full capacity.
        live = (count_now > MAP_OBJECTS) ? MAP_OBJECTS : ADDR_W'(count_now);
        case (op)
            CMD_FIND:
            begin
                // First fit over the live objects only; bits past the count are ignored.
                r.status = STAT_FULL;
                found = 1'b0;
                idx = '0;
                while (!found && idx < live) begin
                    if (!occupancy[idx >> 3][idx[2:0]]) begin
                        found = 1'b1;
                        r.status = STAT_OK;
                        // Wraps modulo 2^32.
                        r.free_address = idx * ADDR_W'(size_now) + base_now;
                    end
                    idx++;
                end
            end
            CMD_MARK_USED, CMD_MARK_FREE:
            begin
                if (addr < base_now || size_now == '0) begin
                    r.status = STAT_RANGE;
                end else begin
                    obj = (addr - base_now) / ADDR_W'(size_now);
                    if (obj >= live) begin
                        r.status = STAT_RANGE;
                    end else begin
                        mask = BYTE_W'(1) << obj[2:0];
                        if (op == CMD_MARK_USED)
                            occupancy[obj >> 3] = occupancy[obj >> 3] | mask;
                        else
                            occupancy[obj >> 3] = occupancy[obj >> 3] & ~mask;
                        // Report the byte even when the bit did not change.
                        r.store_write = 1'b1;
                        r.store_index = BIDX_W'(obj >> 3);
                        r.store_byte  = occupancy[obj >> 3];
                    end
                end
            end
            default:
            begin
                // Every 9-bit index lies inside the 512-byte map.
                occupancy[bidx] = bdata;
                r.store_write = 1'b1;
                r.store_index = bidx;
                r.store_byte  = bdata;
            end
        endcase
        return r;
    endfunction

    // Driver: offer queued commands, predict each one as its transaction completes.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cmd_bus.valid      <= 1'b0;
            cmd_bus.command    <= CMD_FIND;
            cmd_bus.address    <= '0;
            cmd_bus.byte_index <= '0;
            cmd_bus.byte_data  <= '0;
            send_gap = 0;
        end else begin
            if (cmd_bus.valid && cmd_bus.ready)
                predicted_replies.push_back(apply_command(cmd_e'(cmd_bus.command),
                    cmd_bus.address, cmd_bus.byte_index, cmd_bus.byte_data));
            // Hold the current offer until it is taken.
            if (!cmd_bus.valid || cmd_bus.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    cmd_bus.valid <= 1'b0;
                end else if (command_backlog.size() == 0) begin
                    cmd_bus.valid <= 1'b0;
                end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                    // Insert an idle burst.
                    send_gap = $urandom_range(0, 2);
                    cmd_bus.valid <= 1'b0;
                end else begin
                    next_cmd = command_backlog.pop_front();
                    cmd_bus.valid      <= 1'b1;
                    cmd_bus.command    <= next_cmd.op;
                    cmd_bus.address    <= next_cmd.addr;
                    cmd_bus.byte_index <= next_cmd.bidx;
                    cmd_bus.byte_data  <= next_cmd.bdata;
                end
            end
        end
    end

    // Monitor: take replies, compare against the oldest prediction, stall at random.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            res_bus.ready <= 1'b0;
            recv_gap = 0;
            long_hold_left = 0;
        end else begin
            if (res_bus.valid && res_bus.ready) begin
                replies_seen++;
                if (predicted_replies.size() == 0) begin
                    flag_mismatch("reply with nothing predicted");
                end else begin
                    alloc_reply_t want;
                    want = predicted_replies.pop_front();
                    if (res_bus.free_address !== want.free_address)
                        flag_mismatch($sformatf("free_address got %h want %h",
                                                res_bus.free_address, want.free_address));
                    if (res_bus.status !== want.status)
                        flag_mismatch($sformatf("status got %0d want %0d",
                                                res_bus.status, want.status));
                    if (res_bus.store_write !== want.store_write)
                        flag_mismatch($sformatf("store_write got %b want %b",
                                                res_bus.store_write, want.store_write));
                    if (res_bus.store_index !== want.store_index)
                        flag_mismatch($sformatf("store_index got %0d want %0d",
                                                res_bus.store_index, want.store_index));
                    if (res_bus.store_byte !== want.store_byte)
                        flag_mismatch($sformatf("store_byte got %h want %h",
                                                res_bus.store_byte, want.store_byte));
                end
            end
            if (long_hold_left > 0) begin
                long_hold_left--;
                res_bus.ready <= 1'b0;
            end else if (!long_hold_done && replies_seen >= 150 &&
                         command_backlog.size() >= 16) begin
                // Back up the block once while commands keep coming.
                long_hold_done = 1'b1;
                long_hold_left = LONG_HOLD - 1;
                res_bus.ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                res_bus.ready <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                recv_gap = $urandom_range(0, 2);
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= 1'b1;
            end
        end
    end

    task automatic queue_cmd(input cmd_e op, input logic [ADDR_W-1:0] addr,
                             input logic [BIDX_W-1:0] bidx, input logic [BYTE_W-1:0] bdata);
        alloc_cmd_t c;
        c.op = op;
        c.addr = addr;
        c.bidx = bidx;
        c.bdata = bdata;
        command_backlog.push_back(c);
    endtask

    // Wait until every queued command has gone and every reply has come back.
    task automatic wait_drained();
        while (command_backlog.size() != 0 || cmd_bus.valid || predicted_replies.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Write all three registers back to back; only call while the block is idle.
    task automatic apply_settings(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] size,
                                  input logic [ADDR_W-1:0] count);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BASE;
        cfg_data  <= base;
        @(posedge clk);
        cfg_index <= CFG_SIZE;
        cfg_data  <= size;
        @(posedge clk);
        cfg_index <= CFG_COUNT;
        cfg_data  <= count;
        @(posedge clk);
        cfg_we    <= 1'b0;
        base_now  = base;
        size_now  = size[SIZE_W-1:0];
        count_now = count[COUNT_W-1:0];
    endtask

    // Mostly well-formed traffic for the current settings, some noise.
    function automatic alloc_cmd_t random_command();
        alloc_cmd_t  c;
        int unsigned live;
        int unsigned pick;
        int unsigned obj;
        int unsigned off;
        c.op    = CMD_FIND;
        c.addr  = $urandom;
        c.bidx  = $urandom_range(0, MAP_BYTES - 1);
        c.bdata = $urandom_range(0, 255);
        live = (count_now > MAP_OBJECTS) ? MAP_OBJECTS : count_now;
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            c.op = CMD_FIND;
        end else if (pick < 68) begin
            c.op = (pick < 50) ? CMD_MARK_USED : CMD_MARK_FREE;
            if (live != 0) begin
                // Favor low objects so finds have to scan further.
                if ($urandom_range(0, 1) == 0)
                    obj = $urandom_range(0, ((live < 96) ? live : 96) - 1);
                else
                    obj = $urandom_range(0, live - 1);
                off = (size_now == 0) ? 0 : $urandom_range(0, size_now - 1);
                c.addr = base_now + obj * size_now + off;
            end
        end else if (pick < 83) begin
            c.op = CMD_LOAD;
            if ($urandom_range(0, 1) == 0)
                c.bidx = $urandom_range(0, (live / 8 < 16) ? live / 8 : 16);
            if ($urandom_range(0, 2) == 0)
                c.bdata = 8'hff;
        end else begin
            c.op = cmd_e'($urandom_range(0, 3));
        end
        return c;
    endfunction

    task automatic run_phase(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] size,
                             input logic [ADDR_W-1:0] count, input int items);
        wait_drained();
        apply_settings(base, size, count);
        repeat (items) command_backlog.push_back(random_command());
        wait_drained();
    endtask

    initial begin
        // Drive every input to a known level from time zero.
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_BASE;
        cfg_data           = '0;
        cmd_bus.valid      = 1'b0;
        cmd_bus.command    = CMD_FIND;
        cmd_bus.address    = '0;
        cmd_bus.byte_index = '0;
        cmd_bus.byte_data  = '0;
        res_bus.ready      = 1'b0;
        error_count    = 0;
        cycle_count    = 0;
        replies_seen   = 0;
        long_hold_done = 1'b0;
        gaps_on        = 1'b1;
        base_now  = BASE_RESET;
        size_now  = SIZE_RESET;
        count_now = COUNT_RESET;
        foreach (occupancy[i])
            occupancy[i] = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: base 0, 1 KiB objects, full 4096 count; map empty.
        queue_cmd(CMD_FIND, '0, '0, '0);
        queue_cmd(CMD_MARK_USED, 32'h0000_0000, '0, '0);
        queue_cmd(CMD_FIND, '0, '0, '0);
        // Same object again: bit already set, byte still reported.
        queue_cmd(CMD_MARK_USED, 32'h0000_03ff, 9'h1ff, 8'hff);
        // Far beyond the last object.
        queue_cmd(CMD_MARK_FREE, 32'hffff_ffff, '0, '0);
        // Last object, then one past it.
        queue_cmd(CMD_MARK_USED, 32'h003f_ffff, '0, '0);
        queue_cmd(CMD_MARK_USED, 32'h0040_0000, '0, '0);
        queue_cmd(CMD_LOAD, '0, 9'h1ff, 8'hff);
        queue_cmd(CMD_LOAD, '0, 9'h000, 8'hff);
        queue_cmd(CMD_FIND, '0, '0, '0);
        queue_cmd(CMD_LOAD, 32'hffff_ffff, 9'h000, 8'h00);
        // Free an object that is already free.
        queue_cmd(CMD_MARK_FREE, 32'h0000_0000, '0, '0);
        wait_drained();

        // Zero object size: marks rejected, find returns the base.
        apply_settings(32'h0000_1000, 32'd0, 32'd8);
        queue_cmd(CMD_MARK_USED, 32'h0000_1000, '0, '0);
        queue_cmd(CMD_FIND, '0, '0, '0);
        // Fill the eight live objects: map full.
        queue_cmd(CMD_LOAD, '0, 9'h000, 8'hff);
        queue_cmd(CMD_FIND, '0, '0, '0);
        wait_drained();

        // High base, largest power-of-two size, count above capacity: found address wraps.
        apply_settings(32'hffff_ff00, 32'd65536, 32'd8191);
        queue_cmd(CMD_FIND, '0, '0, '0);
        queue_cmd(CMD_MARK_FREE, 32'hffff_ffff, '0, '0);
        // Below the base.
        queue_cmd(CMD_MARK_USED, 32'h0000_0010, '0, '0);
        queue_cmd(CMD_FIND, '0, '0, '0);
        wait_drained();

        // No live objects at all.
        apply_settings(32'h0000_0000, 32'd1, 32'd0);
        queue_cmd(CMD_FIND, '0, '0, '0);
        queue_cmd(CMD_MARK_USED, 32'h0000_0000, '0, '0);

        // Random traffic across a spread of settings.
        run_phase(32'h0000_0000, 32'd1024, 32'd4096, 120);
        run_phase($urandom_range(0, 32'h7fff_ffff), 32'd1, 32'd100, 100);
        run_phase($urandom, $urandom_range(1, 131071), $urandom_range(0, 8191), 100);
        run_phase(32'hffff_ffff, 32'd131071, 32'd4096, 50);
        run_phase(32'h0000_0000, 32'd65536, 32'd8191, 120);
        // Last stretch runs flat out on both sides.
        gaps_on = 1'b0;
        run_phase($urandom_range(0, 32'h0010_0000), 32'd7, 32'd1000, 140);

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (predicted_replies.size() != 0)
            flag_mismatch($sformatf("%0d replies never arrived", predicted_replies.size()));
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
